[design/ps2ht_pkg.sv]
// ps2ht_pkg: shared types and constants for the PS/2 host command transmitter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ps2ht_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StatusW    = 2;

  localparam logic [CfgIdxW-1:0] CFG_INHIBIT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT = 2'd2;

  localparam logic [CfgWidth-1:0] INHIBIT_RST = 16'd120;
  localparam logic [CfgWidth-1:0] HOLD_RST    = 16'd10;
  localparam logic [CfgWidth-1:0] TIMEOUT_RST = 16'd16000;

  localparam logic [StatusW-1:0] ST_OK     = 2'd0;
  localparam logic [StatusW-1:0] ST_NO_ACK = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_CLK = 2'd2;

  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_SEND = 1'b1;

  typedef struct packed {
    logic [CfgWidth-1:0] inhibit_ticks;
    logic [CfgWidth-1:0] start_hold_ticks;
    logic [CfgWidth-1:0] edge_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] command_byte;
    logic             clk_line;
    logic             data_line;
  } item_t;

  typedef struct packed {
    logic               clk_pull_low;
    logic               data_pull_low;
    logic               receive_enable;
    logic               busy_res;
    logic               done_res;
    logic [StatusW-1:0] send_status;
  } result_t;

endpackage
`default_nettype wire

[design/ps2ht_if.sv]
// ps2ht_in_if and ps2ht_out_if: valid/ready channels for tick items and results.
// Depends on ps2ht_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ps2ht_in_if;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic [ps2ht_pkg::ByteW-1:0]  command_byte;
  logic                         clk_line;
  logic                         data_line;

  modport source (output valid, mode, command_byte, clk_line, data_line, input ready);
  modport sink   (input valid, mode, command_byte, clk_line, data_line, output ready);
endinterface

interface ps2ht_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clk_pull_low;
  logic                          data_pull_low;
  logic                          receive_enable;
  logic                          busy_res;
  logic                          done_res;
  logic [ps2ht_pkg::StatusW-1:0] send_status;

  modport source (output valid, clk_pull_low, data_pull_low, receive_enable, busy_res,
                  done_res, send_status, input ready);
  modport sink   (input valid, clk_pull_low, data_pull_low, receive_enable, busy_res,
                  done_res, send_status, output ready);
endinterface
`default_nettype wire

[design/ps2ht_core.sv]
// ps2ht_core: transmit sequencer state and the per-item step logic.
// Depends on ps2ht_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ps2ht_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire ps2ht_pkg::item_t item,
  input  wire ps2ht_pkg::cfg_t  cfg,
  output ps2ht_pkg::result_t    res
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_INHIBIT, PH_HOLD, PH_FIRST_LOW, PH_BIT_HIGH, PH_BIT_LOW,
    PH_PAR_HIGH, PH_PAR_LOW, PH_STOP_HIGH, PH_ACK_LOW, PH_END_HIGH
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic [3:0]                          bit_index_r, bit_index_nxt;
  logic [ps2ht_pkg::ByteW-1:0]         shift_r, shift_nxt;
  logic                                parity_r, parity_nxt;
  logic [ps2ht_pkg::CfgWidth-1:0]      tick_r, tick_nxt;
  logic                                clk_drv_r, clk_drv_nxt;
  logic                                data_drv_r, data_drv_nxt;
  logic                                rx_en_r, rx_en_nxt;

  logic [ps2ht_pkg::CfgWidth:0]        tick_inc;
  logic [ps2ht_pkg::CfgWidth-1:0]      delay_lim;
  logic                                delay_end;
  logic                                want_high;
  logic                                seen;
  logic                                timed_out;
  logic                                done;
  logic [ps2ht_pkg::StatusW-1:0]       status;

  assign tick_inc  = {1'b0, tick_r} + {{ps2ht_pkg::CfgWidth{1'b0}}, 1'b1};
  assign delay_lim = (phase_r == PH_INHIBIT) ? cfg.inhibit_ticks : cfg.start_hold_ticks;
  assign delay_end = tick_inc >= {1'b0, delay_lim};
  assign want_high = (phase_r == PH_BIT_HIGH) || (phase_r == PH_PAR_HIGH) ||
                     (phase_r == PH_STOP_HIGH) || (phase_r == PH_END_HIGH);
  assign seen      = item.clk_line == want_high;
  assign timed_out = tick_r >= cfg.edge_timeout_ticks;

  always_comb begin
    phase_nxt     = phase_r;
    bit_index_nxt = bit_index_r;
    shift_nxt     = shift_r;
    parity_nxt    = parity_r;
    tick_nxt      = tick_r;
    clk_drv_nxt   = clk_drv_r;
    data_drv_nxt  = data_drv_r;
    rx_en_nxt     = rx_en_r;
    done          = 1'b0;
    status        = ps2ht_pkg::ST_OK;

    if (item.mode == ps2ht_pkg::MODE_SEND) begin
      if (phase_r == PH_IDLE) begin
        shift_nxt     = item.command_byte;
        bit_index_nxt = 4'd0;
        parity_nxt    = 1'b0;
        tick_nxt      = '0;
        clk_drv_nxt   = 1'b1;
        data_drv_nxt  = 1'b0;
        rx_en_nxt     = 1'b0;
        phase_nxt     = PH_INHIBIT;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
        end
        PH_INHIBIT, PH_HOLD: begin
          if (delay_end) begin
            tick_nxt = '0;
            if (phase_r == PH_INHIBIT) begin
              data_drv_nxt = 1'b1;
              phase_nxt    = PH_HOLD;
            end else begin
              clk_drv_nxt = 1'b0;
              phase_nxt   = PH_FIRST_LOW;
            end
          end else begin
            tick_nxt = tick_inc[ps2ht_pkg::CfgWidth-1:0];
          end
        end
        PH_FIRST_LOW, PH_BIT_HIGH, PH_BIT_LOW, PH_PAR_HIGH, PH_PAR_LOW,
        PH_STOP_HIGH, PH_ACK_LOW, PH_END_HIGH: begin
          if (seen || timed_out) begin
            tick_nxt = '0;
            case (phase_r)
              PH_FIRST_LOW: begin
                if (seen) begin
                  data_drv_nxt  = ~shift_r[0];
                  parity_nxt    = parity_r ^ shift_r[0];
                  shift_nxt     = {1'b0, shift_r[ps2ht_pkg::ByteW-1:1]};
                  bit_index_nxt = 4'd1;
                  phase_nxt     = PH_BIT_HIGH;
                end else begin
                  done   = 1'b1;
                  status = ps2ht_pkg::ST_NO_CLK;
                end
              end
              PH_BIT_HIGH: phase_nxt = PH_BIT_LOW;
              PH_BIT_LOW: begin
                if (bit_index_r < 4'd8) begin
                  data_drv_nxt  = ~shift_r[0];
                  parity_nxt    = parity_r ^ shift_r[0];
                  shift_nxt     = {1'b0, shift_r[ps2ht_pkg::ByteW-1:1]};
                  bit_index_nxt = bit_index_r + 4'd1;
                  phase_nxt     = PH_BIT_HIGH;
                end else begin
                  data_drv_nxt = parity_r;
                  phase_nxt    = PH_PAR_HIGH;
                end
              end
              PH_PAR_HIGH: phase_nxt = PH_PAR_LOW;
              PH_PAR_LOW: begin
                data_drv_nxt = 1'b0;
                phase_nxt    = PH_STOP_HIGH;
              end
              PH_STOP_HIGH: begin
                data_drv_nxt = 1'b0;
                phase_nxt    = PH_ACK_LOW;
              end
              PH_ACK_LOW: begin
                if (!item.data_line) begin
                  phase_nxt = PH_END_HIGH;
                end else begin
                  done   = 1'b1;
                  status = ps2ht_pkg::ST_NO_ACK;
                end
              end
              PH_END_HIGH: begin
                done   = 1'b1;
                status = ps2ht_pkg::ST_OK;
              end
              default: phase_nxt = phase_r;
            endcase
          end else begin
            tick_nxt = tick_inc[ps2ht_pkg::CfgWidth-1:0];
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
      if (done) begin
        phase_nxt    = PH_IDLE;
        tick_nxt     = '0;
        clk_drv_nxt  = 1'b0;
        data_drv_nxt = 1'b0;
        rx_en_nxt    = 1'b1;
      end
    end
  end

  always_comb begin
    res.clk_pull_low   = clk_drv_nxt;
    res.data_pull_low  = data_drv_nxt;
    res.receive_enable = rx_en_nxt;
    res.busy_res       = phase_nxt != PH_IDLE;
    res.done_res       = done;
    res.send_status    = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_index_r <= 4'd0;
      shift_r     <= '0;
      parity_r    <= 1'b0;
      tick_r      <= '0;
      clk_drv_r   <= 1'b0;
      data_drv_r  <= 1'b0;
      rx_en_r     <= 1'b1;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      bit_index_r <= bit_index_nxt;
      shift_r     <= shift_nxt;
      parity_r    <= parity_nxt;
      tick_r      <= tick_nxt;
      clk_drv_r   <= clk_drv_nxt;
      data_drv_r  <= data_drv_nxt;
      rx_en_r     <= rx_en_nxt;
    end
  end

endmodule
`default_nettype wire

[design/ps2_host_command_transmitter.sv]
// Results are registered: an item in the input register is stepped and captured in the
// result register. Throughput: one item per cycle while out_ch.ready holds; the input
// register takes the next item while a result waits; the sequencer steps once per item.
// Reset (rst_n low, synchronous): sequencer idle, lines released, receive enabled,
// configuration back to 120 / 10 / 16000 ticks, both pipeline registers empty.
`timescale 1ns / 1ps
`default_nettype none
module ps2_host_command_transmitter (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  ps2ht_in_if.sink                               in_ch,
  ps2ht_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [ps2ht_pkg::CfgIdxW-1:0]     cfg_index,
  input  wire logic [ps2ht_pkg::CfgWidth-1:0]    cfg_wdata
);

  ps2ht_pkg::cfg_t    cfg_r;
  logic               in_valid_r;
  ps2ht_pkg::item_t   in_item_r;
  logic               out_valid_r;
  ps2ht_pkg::result_t out_res_r;
  ps2ht_pkg::result_t step_res;
  logic               advance;

  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.inhibit_ticks      <= ps2ht_pkg::INHIBIT_RST;
      cfg_r.start_hold_ticks   <= ps2ht_pkg::HOLD_RST;
      cfg_r.edge_timeout_ticks <= ps2ht_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ps2ht_pkg::CFG_INHIBIT: cfg_r.inhibit_ticks      <= cfg_wdata;
        ps2ht_pkg::CFG_HOLD:    cfg_r.start_hold_ticks   <= cfg_wdata;
        ps2ht_pkg::CFG_TIMEOUT: cfg_r.edge_timeout_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r.mode         <= in_ch.mode;
      in_item_r.command_byte <= in_ch.command_byte;
      in_item_r.clk_line     <= in_ch.clk_line;
      in_item_r.data_line    <= in_ch.data_line;
    end
  end

  ps2ht_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (in_item_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.clk_pull_low   = out_res_r.clk_pull_low;
  assign out_ch.data_pull_low  = out_res_r.data_pull_low;
  assign out_ch.receive_enable = out_res_r.receive_enable;
  assign out_ch.busy_res       = out_res_r.busy_res;
  assign out_ch.done_res       = out_res_r.done_res;
  assign out_ch.send_status    = out_res_r.send_status;

endmodule
`default_nettype wire

[bench/ps2_host_command_transmitter_tb.sv]
// ps2_host_command_transmitter_tb: self-checking bench for the PS/2 host command transmitter.
// Emulates the device clock and acknowledge and checks each result against a local sequencer
// model. Depends on ps2ht_pkg, ps2ht_in_if, ps2ht_out_if and the transmitter itself.
`timescale 1ns / 1ps
module ps2_host_command_transmitter_tb;

  localparam int unsigned RandomTicks = 850;
  localparam int unsigned DrainCycles = 4;

  typedef enum logic [3:0] {
    SQ_IDLE, SQ_INHIBIT, SQ_HOLD, SQ_FIRST_LOW, SQ_BIT_HIGH, SQ_BIT_LOW,
    SQ_PAR_HIGH, SQ_PAR_LOW, SQ_STOP_HIGH, SQ_ACK_LOW, SQ_END_HIGH
  } seq_phase_t;

  typedef enum logic [1:0] {WAIT_PENDING, WAIT_SEEN, WAIT_EXPIRED} wait_outcome_t;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                cfg_we;
  logic [ps2ht_pkg::CfgIdxW-1:0]       cfg_index;
  logic [ps2ht_pkg::CfgWidth-1:0]      cfg_wdata;

  ps2ht_in_if  in_ch ();
  ps2ht_out_if out_ch ();

  ps2_host_command_transmitter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // sequencer model
  ps2ht_pkg::cfg_t tx_cfg;
  seq_phase_t      tx_phase;
  logic [3:0]      tx_bit_count;
  logic [7:0]      tx_shift;
  logic            tx_parity;
  logic [15:0]     tx_ticks;
  logic            drv_clk;
  logic            drv_data;
  logic            rx_enable;

  ps2ht_pkg::result_t predicted_drive_q[$];
  int unsigned        mismatches;
  int unsigned        device_ticks;
  bit                 idling;
  int unsigned        burst_left;
  int unsigned        stall_left;

  always #5 clk = ~clk;

  function automatic void reset_model();
    tx_cfg.inhibit_ticks      = ps2ht_pkg::INHIBIT_RST;
    tx_cfg.start_hold_ticks   = ps2ht_pkg::HOLD_RST;
    tx_cfg.edge_timeout_ticks = ps2ht_pkg::TIMEOUT_RST;
    tx_phase     = SQ_IDLE;
    tx_bit_count = '0;
    tx_shift     = '0;
    tx_parity    = 1'b0;
    tx_ticks     = '0;
    drv_clk      = 1'b0;
    drv_data     = 1'b0;
    rx_enable    = 1'b1;
  endfunction

  function automatic bit delay_elapsed(logic [15:0] limit);
    if ({1'b0, tx_ticks} + 17'd1 >= {1'b0, limit}) begin
      tx_ticks = '0;
      return 1'b1;
    end
    tx_ticks = tx_ticks + 16'd1;
    return 1'b0;
  endfunction

  function automatic wait_outcome_t await_level(logic line, logic want);
    if (line == want) begin
      tx_ticks = '0;
      return WAIT_SEEN;
    end
    if (tx_ticks >= tx_cfg.edge_timeout_ticks) begin
      tx_ticks = '0;
      return WAIT_EXPIRED;
    end
    tx_ticks = tx_ticks + 16'd1;
    return WAIT_PENDING;
  endfunction

  // pull data low for a zero bit, release it for a one
  function automatic void shift_out_bit();
    drv_data  = ~tx_shift[0];
    tx_parity = tx_parity ^ tx_shift[0];
    tx_shift  = tx_shift >> 1;
  endfunction

  function automatic ps2ht_pkg::result_t step_transmitter(ps2ht_pkg::item_t it);
    ps2ht_pkg::result_t            r;
    logic                          finished;
    logic [ps2ht_pkg::StatusW-1:0] status;
    finished = 1'b0;
    status   = ps2ht_pkg::ST_OK;
    if (it.mode == ps2ht_pkg::MODE_SEND) begin
      if (tx_phase == SQ_IDLE) begin
        tx_shift     = it.command_byte;
        tx_bit_count = '0;
        tx_parity    = 1'b0;
        tx_ticks     = '0;
        drv_clk      = 1'b1;
        drv_data     = 1'b0;
        rx_enable    = 1'b0;
        tx_phase     = SQ_INHIBIT;
      end
    end else begin
      case (tx_phase)
        SQ_INHIBIT: begin
          if (delay_elapsed(tx_cfg.inhibit_ticks)) begin
            drv_data = 1'b1;
            tx_phase = SQ_HOLD;
          end
        end
        SQ_HOLD: begin
          if (delay_elapsed(tx_cfg.start_hold_ticks)) begin
            drv_clk  = 1'b0;
            tx_phase = SQ_FIRST_LOW;
          end
        end
        SQ_FIRST_LOW: begin
          case (await_level(it.clk_line, 1'b0))
            WAIT_SEEN: begin
              shift_out_bit();
              tx_bit_count = 4'd1;
              tx_phase     = SQ_BIT_HIGH;
            end
            WAIT_EXPIRED: begin
              finished = 1'b1;
              status   = ps2ht_pkg::ST_NO_CLK;
            end
            default: ;
          endcase
        end
        SQ_BIT_HIGH: begin
          if (await_level(it.clk_line, 1'b1) != WAIT_PENDING) tx_phase = SQ_BIT_LOW;
        end
        SQ_BIT_LOW: begin
          if (await_level(it.clk_line, 1'b0) != WAIT_PENDING) begin
            if (tx_bit_count < 4'd8) begin
              shift_out_bit();
              tx_bit_count = tx_bit_count + 4'd1;
              tx_phase     = SQ_BIT_HIGH;
            end else begin
              // odd parity: pull low when the ones count is already odd
              drv_data = tx_parity;
              tx_phase = SQ_PAR_HIGH;
            end
          end
        end
        SQ_PAR_HIGH: begin
          if (await_level(it.clk_line, 1'b1) != WAIT_PENDING) tx_phase = SQ_PAR_LOW;
        end
        SQ_PAR_LOW: begin
          if (await_level(it.clk_line, 1'b0) != WAIT_PENDING) begin
            drv_data = 1'b0;
            tx_phase = SQ_STOP_HIGH;
          end
        end
        SQ_STOP_HIGH: begin
          if (await_level(it.clk_line, 1'b1) != WAIT_PENDING) begin
            drv_data = 1'b0;
            tx_phase = SQ_ACK_LOW;
          end
        end
        SQ_ACK_LOW: begin
          if (await_level(it.clk_line, 1'b0) != WAIT_PENDING) begin
            if (!it.data_line) begin
              tx_phase = SQ_END_HIGH;
            end else begin
              finished = 1'b1;
              status   = ps2ht_pkg::ST_NO_ACK;
            end
          end
        end
        SQ_END_HIGH: begin
          if (await_level(it.clk_line, 1'b1) != WAIT_PENDING) begin
            finished = 1'b1;
            status   = ps2ht_pkg::ST_OK;
          end
        end
        default: tx_phase = SQ_IDLE;
      endcase
      if (finished) begin
        tx_phase  = SQ_IDLE;
        tx_ticks  = '0;
        drv_clk   = 1'b0;
        drv_data  = 1'b0;
        rx_enable = 1'b1;
      end
    end
    r.clk_pull_low   = drv_clk;
    r.data_pull_low  = drv_data;
    r.receive_enable = rx_enable;
    r.busy_res       = (tx_phase != SQ_IDLE);
    r.done_res       = finished;
    r.send_status    = finished ? status : ps2ht_pkg::ST_OK;
    return r;
  endfunction

  function automatic ps2ht_pkg::item_t tick_item(logic clk_l, logic data_l);
    ps2ht_pkg::item_t it;
    it.mode         = ps2ht_pkg::MODE_TICK;
    it.command_byte = 8'($urandom_range(0, 255));
    it.clk_line     = clk_l;
    it.data_line    = data_l;
    return it;
  endfunction

  function automatic ps2ht_pkg::item_t send_request(logic [7:0] cmd);
    ps2ht_pkg::item_t it;
    it.mode         = ps2ht_pkg::MODE_SEND;
    it.command_byte = cmd;
    it.clk_line     = 1'($urandom_range(0, 1));
    it.data_line    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic send_item(ps2ht_pkg::item_t it);
    int unsigned gap;
    if (idling && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= it.mode;
    in_ch.command_byte <= it.command_byte;
    in_ch.clk_line     <= it.clk_line;
    in_ch.data_line    <= it.data_line;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted_drive_q.push_back(step_transmitter(it));
  endtask

  // hold the input and wait until every transfer has been answered
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (predicted_drive_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_register(logic [ps2ht_pkg::CfgIdxW-1:0] idx,
                                logic [ps2ht_pkg::CfgWidth-1:0] value);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ps2ht_pkg::CFG_INHIBIT: tx_cfg.inhibit_ticks      = value;
      ps2ht_pkg::CFG_HOLD:    tx_cfg.start_hold_ticks   = value;
      ps2ht_pkg::CFG_TIMEOUT: tx_cfg.edge_timeout_ticks = value;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] inhibit, logic [15:0] hold, logic [15:0] timeout);
    write_register(ps2ht_pkg::CFG_INHIBIT, inhibit);
    write_register(ps2ht_pkg::CFG_HOLD, hold);
    write_register(ps2ht_pkg::CFG_TIMEOUT, timeout);
  endtask

  // play the device side until the send ends; stuck_ph never shows its level
  task automatic run_device(int unsigned miss_per16, int unsigned nack_per16,
                            seq_phase_t stuck_ph, int unsigned noise_per16);
    logic want;
    logic clk_l;
    logic dat_l;
    bit   waiting;
    while (tx_phase != SQ_IDLE) begin
      if ($urandom_range(0, 15) < noise_per16) begin
        if ($urandom_range(0, 1) == 0) send_item(send_request(8'($urandom_range(0, 255))));
        else send_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        continue;
      end
      waiting = 1'b1;
      case (tx_phase)
        SQ_FIRST_LOW, SQ_BIT_LOW, SQ_PAR_LOW, SQ_ACK_LOW: want = 1'b0;
        SQ_BIT_HIGH, SQ_PAR_HIGH, SQ_STOP_HIGH, SQ_END_HIGH: want = 1'b1;
        default: begin
          waiting = 1'b0;
          want    = 1'($urandom_range(0, 1));
        end
      endcase
      if (waiting && (tx_phase == stuck_ph || $urandom_range(0, 15) < miss_per16)) clk_l = ~want;
      else clk_l = want;
      if (tx_phase == SQ_ACK_LOW) dat_l = ($urandom_range(0, 15) < nack_per16);
      else dat_l = 1'($urandom_range(0, 1));
      send_item(tick_item(clk_l, dat_l));
      device_ticks++;
    end
  endtask

  task automatic test_idle_and_defaults();
    repeat (4) send_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    send_item(send_request(8'hA5));
    run_device(0, 0, SQ_IDLE, 0);
  endtask

  task automatic test_short_delays_and_ack();
    configure(16'd0, 16'd1, 16'd4);
    send_item(send_request(8'h00));
    send_item(send_request(8'hFF));
    run_device(0, 0, SQ_IDLE, 0);
    configure(16'd1, 16'd0, 16'd4);
    send_item(send_request(8'hFF));
    run_device(0, 16, SQ_IDLE, 0);
  endtask

  task automatic test_wait_timeouts();
    configure(16'd2, 16'd2, 16'd0);
    send_item(send_request(8'h3C));
    run_device(16, 0, SQ_IDLE, 0);
    write_register(ps2ht_pkg::CFG_TIMEOUT, 16'd1);
    send_item(send_request(8'hC3));
    run_device(0, 0, SQ_BIT_HIGH, 0);
    send_item(send_request(8'h5A));
    run_device(0, 0, SQ_ACK_LOW, 0);
    send_item(send_request(8'h96));
    run_device(0, 16, SQ_ACK_LOW, 0);
    send_item(send_request(8'h69));
    run_device(0, 0, SQ_END_HIGH, 0);
  endtask

  task automatic test_extreme_settings();
    idling = 1'b0;
    configure(16'd150, 16'd0, 16'hFFFF);
    send_item(send_request(8'h81));
    run_device(2, 0, SQ_IDLE, 0);
    configure(16'd0, 16'd150, 16'd1);
    send_item(send_request(8'h7E));
    run_device(0, 0, SQ_IDLE, 0);
  endtask

  task automatic test_random_traffic();
    seq_phase_t stuck_ph;
    device_ticks = 0;
    while (device_ticks < RandomTicks) begin
      idling = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0)
        configure(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                  16'($urandom_range(0, 5)));
      repeat ($urandom_range(0, 2))
        send_item(tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      stuck_ph = SQ_IDLE;
      if ($urandom_range(0, 3) == 0)
        stuck_ph = seq_phase_t'($urandom_range(SQ_FIRST_LOW, SQ_END_HIGH));
      send_item(send_request(8'($urandom_range(0, 255))));
      run_device($urandom_range(0, 6), $urandom_range(0, 8), stuck_ph, $urandom_range(0, 1));
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n || !idling) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [1:0] want_v, logic [1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    ps2ht_pkg::result_t want_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_drive_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, got clk %0b data %0b rx %0b",
                 $time, out_ch.clk_pull_low, out_ch.data_pull_low, out_ch.receive_enable);
        mismatches++;
      end else begin
        want_r = predicted_drive_q.pop_front();
        check_field("clk_pull_low", {1'b0, want_r.clk_pull_low},
                    {1'b0, out_ch.clk_pull_low});
        check_field("data_pull_low", {1'b0, want_r.data_pull_low},
                    {1'b0, out_ch.data_pull_low});
        check_field("receive_enable", {1'b0, want_r.receive_enable},
                    {1'b0, out_ch.receive_enable});
        check_field("busy_res", {1'b0, want_r.busy_res}, {1'b0, out_ch.busy_res});
        check_field("done_res", {1'b0, want_r.done_res}, {1'b0, out_ch.done_res});
        check_field("send_status", want_r.send_status, out_ch.send_status);
      end
    end
  end

  initial begin
    #(64'd20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.mode         = ps2ht_pkg::MODE_TICK;
    in_ch.command_byte = '0;
    in_ch.clk_line     = 1'b1;
    in_ch.data_line    = 1'b1;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = ps2ht_pkg::CFG_INHIBIT;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    idling             = 1'b0;
    burst_left         = 0;
    stall_left         = 0;
    mismatches         = 0;
    device_ticks       = 0;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_and_defaults();
    idling = 1'b1;
    test_short_delays_and_ack();
    test_wait_timeouts();
    test_extreme_settings();
    test_random_traffic();
    drain();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/ps2ht_pkg.sv
design/ps2ht_if.sv
design/ps2ht_core.sv
design/ps2_host_command_transmitter.sv
bench/ps2_host_command_transmitter_tb.sv
